@@ design/tti_pkg.sv @@
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types, field widths and codes of the thermistor table interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

    // Field widths
    localparam int RES_W   = 20;
    localparam int TEMP_W  = 17;
    localparam int INDEX_W = 6;
    localparam int EU_W    = 7;
    localparam int STAT_W  = 3;

    // Default table depth and register reset
    localparam int TABLE_DEPTH_DEFAULT = 64;
    localparam logic [EU_W-1:0] ENTRIES_USED_RESET = 7'd35;

    // Divider: magnitude of the product fits in DIV_W bits, two bits a cycle
    localparam int DIV_W     = 38;
    localparam int DIVISOR_W = RES_W;
    localparam int DIV_STEPS = DIV_W / 2;

    // Command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_INTERP  = 3'd0;
    localparam logic [STAT_W-1:0] ST_FIRST   = 3'd1;
    localparam logic [STAT_W-1:0] ST_LAST    = 3'd2;
    localparam logic [STAT_W-1:0] ST_LOADED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERODIV = 3'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_SRCH,
        S_MUL,
        S_ABS,
        S_DIV,
        S_OUT
    } tti_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } tti_div_stat_t;

endpackage

@@ design/tti_ram.sv @@
// ----------------------------------------------------------------------------
// tti_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/tti_divider.sv @@
// ----------------------------------------------------------------------------
// tti_divider
// Iterative unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tti_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tti_pkg::DIV_W-1:0]       dividend,
    input  logic [tti_pkg::DIVISOR_W-1:0]   divisor,
    output logic [tti_pkg::DIV_W-1:0]       quotient,
    output tti_pkg::tti_div_stat_t          stat
);

    localparam int DW    = tti_pkg::DIV_W;
    localparam int VW    = tti_pkg::DIVISOR_W;
    localparam int STEPS = tti_pkg::DIV_STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // Two dependent shift-compare-subtract steps
    always_comb
    begin
        logic [DW-1:0] q;
        logic [VW-1:0] r;
        logic [VW:0]   trial;
        q = quo_reg;
        r = rem_reg;
        for (int i = 0; i < 2; i++)
        begin
            trial = {r, q[DW-1]};
            q = {q[DW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
                q[0] = 1'b1;
            end
            r = trial[VW-1:0];
        end
        quo_next = q;
        rem_next = r;
    end

    // Control: load on start, count down the steps, pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ design/thermistor_table_interpolator.sv @@
// ----------------------------------------------------------------------------
// thermistor_table_interpolator
// Resistance to temperature conversion by table search and interpolation.
// ----------------------------------------------------------------------------
// Input transactions arrive on s_*: s_tuser selects load (0) or convert (1).
// A load writes one resistance/temperature pair into the table RAM and
// answers temperature 0, status loaded. A convert searches the table (sorted
// by falling resistance) and answers a clamped or interpolated temperature
// on m_*, with the status in m_tuser. One result per input transaction.
// A load goes straight to the output; a convert reads the first entry, then
// the last, clamping on either, and else searches the table with at most
// ceil(log2(n-1)) search reads for n used entries (six for the default 35)
// before it interpolates. The table RAM port serves one read per search
// step, and the divider retires two quotient bits per cycle.
// One item is in work at a time; s_tready is high only while the sequencer
// is idle. A result waits in the output register while the receiver stalls,
// and the next item is taken meanwhile; it finishes only once that register
// is free. Reset clears control state and sets entries_used to 35; the
// table is undefined until written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator #(
    parameter int TABLE_DEPTH = tti_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // s_tdata: entry_index[5:0], resistance[25:6], entry_temperature[42:26]
    input  logic [47:0]               s_tdata,
    // s_tuser: cmd[0]
    input  logic [0:0]                s_tuser,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // m_tdata: temperature[16:0]
    output logic [23:0]               m_tdata,
    // m_tuser: status[2:0]
    output logic [2:0]                m_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic                      cfg_we,
    input  logic [tti_pkg::EU_W-1:0]  cfg_wdata
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int RES_W  = tti_pkg::RES_W;
    localparam int TEMP_W = tti_pkg::TEMP_W;
    localparam int MEM_W  = RES_W + TEMP_W;
    localparam int DW     = tti_pkg::DIV_W;
    localparam logic signed [39:0] TEMP_MIN = -40'sd65536;
    localparam logic signed [39:0] TEMP_MAX = 40'sd65535;

    // Input fields
    logic                           in_cmd;
    logic [tti_pkg::INDEX_W-1:0]    in_index;
    logic [RES_W-1:0]               in_res;
    logic [TEMP_W-1:0]              in_temp;

    assign in_index = s_tdata[5:0];
    assign in_res   = s_tdata[25:6];
    assign in_temp  = s_tdata[42:26];
    assign in_cmd   = s_tuser[0];

    // State
    tti_pkg::tti_state_t          state_reg, state_next;
    logic [tti_pkg::EU_W-1:0]     entries_used_reg;
    logic [RES_W-1:0]             x_reg, x_next;
    logic [IDX_W-1:0]             lo_reg, lo_next;
    logic [IDX_W-1:0]             hi_reg, hi_next;
    logic [IDX_W-1:0]             mid_reg, mid_next;
    logic [RES_W-1:0]             rlo_reg, rlo_next;
    logic [RES_W-1:0]             rhi_reg, rhi_next;
    logic [TEMP_W-1:0]            tlo_reg, tlo_next;
    logic [TEMP_W-1:0]            thi_reg, thi_next;
    logic signed [38:0]           num_reg, num_next;
    logic signed [20:0]           dx_reg, dx_next;
    logic                         neg_reg, neg_next;
    logic [TEMP_W-1:0]            pend_temp_reg, pend_temp_next;
    logic [2:0]                   pend_status_reg, pend_status_next;
    logic                         out_valid_reg, out_valid_next;
    logic [TEMP_W-1:0]            out_temp_reg, out_temp_next;
    logic [2:0]                   out_status_reg, out_status_next;

    // RAM and divider signals
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic                         ram_re;
    logic [IDX_W-1:0]             ram_raddr;
    logic [MEM_W-1:0]             ram_rdata;
    logic [RES_W-1:0]             rd_res;
    logic [TEMP_W-1:0]            rd_temp;
    logic                         div_start;
    logic [DW-1:0]                div_dividend;
    logic [RES_W-1:0]             div_divisor;
    logic [DW-1:0]                div_quotient;
    tti_pkg::tti_div_stat_t       div_stat;

    // Search helpers
    logic [IDX_W-1:0]             last_idx;
    logic                         one_or_less;
    logic [IDX_W-1:0]             srch_lo;
    logic [IDX_W-1:0]             srch_hi;
    logic                         srch_more;
    logic [IDX_W:0]               srch_sum;
    logic [IDX_W-1:0]             srch_mid;
    logic                         in_accept;
    logic                         out_free;

    assign rd_res  = ram_rdata[RES_W-1:0];
    assign rd_temp = ram_rdata[MEM_W-1:RES_W];

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == tti_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || m_tready;

    // Last used entry, saturated to the table depth
    assign one_or_less = (entries_used_reg <= 7'd1);
    assign last_idx = (32'(entries_used_reg) > TABLE_DEPTH) ? IDX_W'(TABLE_DEPTH - 1)
                                                            : IDX_W'(entries_used_reg - 7'd1);

    tti_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_temp, in_res}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tti_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // Bracket after the current read narrows it
    always_comb
    begin
        srch_lo = lo_reg;
        srch_hi = hi_reg;
        if (state_reg == tti_pkg::S_RD1)
        begin
            srch_lo = '0;
            srch_hi = last_idx;
        end
        else if (state_reg == tti_pkg::S_SRCH)
        begin
            if (rd_res <= x_reg)
            begin
                srch_hi = mid_reg;
            end
            else
            begin
                srch_lo = mid_reg;
            end
        end
    end

    assign srch_more = ({1'b0, srch_lo} + (IDX_W + 1)'(2)) <= {1'b0, srch_hi};
    assign srch_sum  = {1'b0, srch_lo} + {1'b0, srch_hi};
    assign srch_mid  = srch_sum[IDX_W:1];

    // Sequencer: next state and datapath
    always_comb
    begin
        logic signed [20:0] dx;
        logic signed [17:0] dy;
        logic signed [20:0] dxn;
        logic signed [38:0] num_mag;
        logic signed [20:0] dx_mag;
        logic signed [39:0] qs;
        logic signed [39:0] t;

        state_next       = state_reg;
        x_next           = x_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        rlo_next         = rlo_reg;
        rhi_next         = rhi_reg;
        tlo_next         = tlo_reg;
        thi_next         = thi_reg;
        num_next         = num_reg;
        dx_next          = dx_reg;
        neg_next         = neg_reg;
        pend_temp_next   = pend_temp_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;
        out_temp_next    = out_temp_reg;
        out_status_next  = out_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = IDX_W'(in_index);
        ram_re           = 1'b0;
        ram_raddr        = '0;
        div_start        = 1'b0;
        dx               = $signed({1'b0, rhi_reg}) - $signed({1'b0, rlo_reg});
        dy               = $signed({thi_reg[TEMP_W-1], thi_reg})
                         - $signed({tlo_reg[TEMP_W-1], tlo_reg});
        dxn              = $signed({1'b0, x_reg}) - $signed({1'b0, rlo_reg});
        num_mag          = num_reg[38] ? -num_reg : num_reg;
        dx_mag           = dx_reg[20] ? -dx_reg : dx_reg;
        div_dividend     = num_mag[DW-1:0];
        div_divisor      = dx_mag[RES_W-1:0];
        qs               = neg_reg ? -$signed({2'b00, div_quotient})
                                   : $signed({2'b00, div_quotient});
        t                = $signed({{23{tlo_reg[TEMP_W-1]}}, tlo_reg}) + qs;

        // Drop the output transaction once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tti_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    x_next = in_res;
                    if (in_cmd == tti_pkg::CMD_LOAD)
                    begin
                        ram_we           = (32'(in_index) < TABLE_DEPTH);
                        pend_temp_next   = '0;
                        pend_status_next = tti_pkg::ST_LOADED;
                        state_next       = tti_pkg::S_OUT;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = tti_pkg::S_RD0;
                    end
                end
            end

            // First entry: clamp high side or fetch the last entry
            tti_pkg::S_RD0:
            begin
                lo_next  = '0;
                rlo_next = rd_res;
                tlo_next = rd_temp;
                if (one_or_less || (x_reg > rd_res))
                begin
                    pend_temp_next   = rd_temp;
                    pend_status_next = tti_pkg::ST_FIRST;
                    state_next       = tti_pkg::S_OUT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = last_idx;
                    state_next = tti_pkg::S_RD1;
                end
            end

            // Last entry: clamp low side or start the search
            tti_pkg::S_RD1:
            begin
                hi_next  = last_idx;
                rhi_next = rd_res;
                thi_next = rd_temp;
                if (x_reg <= rd_res)
                begin
                    pend_temp_next   = rd_temp;
                    pend_status_next = tti_pkg::ST_LAST;
                    state_next       = tti_pkg::S_OUT;
                end
                else if (srch_more)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = srch_mid;
                    mid_next   = srch_mid;
                    state_next = tti_pkg::S_SRCH;
                end
                else
                begin
                    state_next = tti_pkg::S_MUL;
                end
            end

            // Narrow the bracket with the midpoint entry
            tti_pkg::S_SRCH:
            begin
                lo_next = srch_lo;
                hi_next = srch_hi;
                if (rd_res <= x_reg)
                begin
                    rhi_next = rd_res;
                    thi_next = rd_temp;
                end
                else
                begin
                    rlo_next = rd_res;
                    tlo_next = rd_temp;
                end
                if (srch_more)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = srch_mid;
                    mid_next   = srch_mid;
                end
                else
                begin
                    state_next = tti_pkg::S_MUL;
                end
            end

            // Slope numerator, or left temperature on a zero divisor
            tti_pkg::S_MUL:
            begin
                if (dx == 21'sd0)
                begin
                    pend_temp_next   = tlo_reg;
                    pend_status_next = tti_pkg::ST_ZERODIV;
                    state_next       = tti_pkg::S_OUT;
                end
                else
                begin
                    num_next   = dy * dxn;
                    dx_next    = dx;
                    state_next = tti_pkg::S_ABS;
                end
            end

            // Hand magnitudes to the divider, keep the quotient sign
            tti_pkg::S_ABS:
            begin
                div_start  = 1'b1;
                neg_next   = num_reg[38] ^ dx_reg[20];
                state_next = tti_pkg::S_DIV;
            end

            // Add the signed quotient and saturate
            tti_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (t < TEMP_MIN)
                    begin
                        pend_temp_next = TEMP_MIN[TEMP_W-1:0];
                    end
                    else if (t > TEMP_MAX)
                    begin
                        pend_temp_next = TEMP_MAX[TEMP_W-1:0];
                    end
                    else
                    begin
                        pend_temp_next = t[TEMP_W-1:0];
                    end
                    pend_status_next = tti_pkg::ST_INTERP;
                    state_next       = tti_pkg::S_OUT;
                end
            end

            // Move the result into the output register when it is free
            tti_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_temp_next   = pend_temp_reg;
                    out_status_next = pend_status_reg;
                    state_next      = tti_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tti_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tti_pkg::S_IDLE;
            out_valid_reg    <= 1'b0;
            entries_used_reg <= tti_pkg::ENTRIES_USED_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                entries_used_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg           <= x_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        mid_reg         <= mid_next;
        rlo_reg         <= rlo_next;
        rhi_reg         <= rhi_next;
        tlo_reg         <= tlo_next;
        thi_reg         <= thi_next;
        num_reg         <= num_next;
        dx_reg          <= dx_next;
        neg_reg         <= neg_next;
        pend_temp_reg   <= pend_temp_next;
        pend_status_reg <= pend_status_next;
        out_temp_reg    <= out_temp_next;
        out_status_reg  <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_temp_reg};
    assign m_tuser  = out_status_reg;

    // Assertions
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !s_tready)
        else $error("input accepted while divider busy");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == tti_pkg::S_DIV))
        else $error("divider done outside divide state");

    a_bracket_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tti_pkg::S_SRCH) |-> (lo_reg < mid_reg) && (mid_reg < hi_reg))
        else $error("search bracket out of order");

    a_load_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_cmd == tti_pkg::CMD_LOAD)) |=> (state_reg == tti_pkg::S_OUT))
        else $error("load did not go to output");

endmodule
